FILE: hdl/kwhm_pkg.sv
// Package for the k-way heap merge block: field widths, input kind codes
// and the default run capacity. No dependencies.
`timescale 1ns / 1ps
package kwhm_pkg;

  localparam int unsigned MaxRunsDef = 16;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned RunW       = 4;
  localparam int unsigned CountW     = 5;

  typedef enum logic [1:0] {
    KIND_FIRST = 2'd0,
    KIND_NEXT  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

endpackage

FILE: hdl/kway_heap_merge.sv
// K-way merge top level: run head key memory, heap slot memory and the
// load / build / sift sequencer. Depends on kwhm_pkg.
`timescale 1ns / 1ps
// Merges up to MAX_RUNS sorted runs of unsigned 64-bit keys. Load one item per
// run (kind 0 first key, kind 2 empty); after the last one the heap is filled
// from the present runs in run order, built bottom-up and the smallest head is
// emitted with its run number. Then give the next key of the emitted run
// (kind 1) or report it exhausted (kind 2); each such item costs a root sift
// down the heap levels, unless it empties the heap. The rate is set by the
// single sift sequencer: each level reads the one or two child slots, then
// their keys from the head key memory (both synchronous reads), then compares.
// A done result ends the pass and the block returns to loading. A result
// waits in the output register; no item is taken while a sift runs.
module kway_heap_merge
  import kwhm_pkg::*;
#(
  parameter int unsigned MAX_RUNS = MaxRunsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [RunW-1:0]   run_i,
  input  logic [KeyW-1:0]   key_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KeyW-1:0]   out_key_o,
  output logic [RunW-1:0]   out_run_o,
  output logic              done_res_o
);

  localparam int unsigned RW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned HW = $clog2(MAX_RUNS + 1);
  localparam int unsigned XW = (RW > CountW) ? RW : CountW;
  localparam int unsigned CW = ((RW + 2) > HW) ? (RW + 2) : HW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILL, ST_SLOAD, ST_SKEY, ST_SKLAT, ST_SRD, ST_SKREAD,
    ST_SCMP, ST_ERD, ST_EKEY, ST_RES, ST_DONE
  } state_e;

  // memories
  logic [KeyW-1:0] key_mem  [MAX_RUNS];
  logic [RW-1:0]   slot_mem [MAX_RUNS];

  logic            k_we, k_re0, k_re1, s_we, s_re0, s_re1;
  logic [RW-1:0]   k_wa, k_ra0, k_ra1, s_wa, s_ra0, s_ra1, s_wd;
  logic [KeyW-1:0] k_wd, kd0_q, kd1_q;
  logic [RW-1:0]   sd0_q, sd1_q;

  always_ff @(posedge clk_i) begin
    if (k_we) key_mem[k_wa] <= k_wd;
    if (k_re0) kd0_q <= key_mem[k_ra0];
    if (k_re1) kd1_q <= key_mem[k_ra1];
    if (s_we) slot_mem[s_wa] <= s_wd;
    if (s_re0) sd0_q <= slot_mem[s_ra0];
    if (s_re1) sd1_q <= slot_mem[s_ra1];
  end

  state_e              state_q, state_d;
  logic [CountW-1:0]   run_count_q;
  logic [MAX_RUNS-1:0] present_q, present_d;
  logic [HW-1:0]       size_q, size_d;
  logic [CountW-1:0]   loaded_q, loaded_d, eff_q, eff_d, bi_q, bi_d;
  logic                merging_q, merging_d, bld_q, bld_d, has_r_q, has_r_d;
  logic [RW-1:0]       sx_q, sx_d, bj_q, bj_d, srun_q, srun_d, top_q, top_d;
  logic [RW-1:0]       cl_q, cl_d, cr0_q, cr0_d, cr1_q, cr1_d;
  logic [KeyW-1:0]     skey_q, skey_d;
  logic                out_valid_q, out_valid_d, done_q, done_d;
  logic [KeyW-1:0]     out_key_q, out_key_d;
  logic [RunW-1:0]     out_run_q, out_run_d;

  logic [CountW-1:0] eff_w;
  logic [RW-1:0]     run_idx, bi_idx;
  logic [CW-1:0]     lpos, rpos;
  logic              bi_present, out_free, take_r;
  logic [KeyW-1:0]   ckey;
  logic [RW-1:0]     crun, cpos;
  logic [HW-1:0]     size_dec;

  always_comb begin
    eff_w = run_count_q;
    if (run_count_q == '0) eff_w = CountW'(1);
    if (int'(run_count_q) > int'(MAX_RUNS)) eff_w = CountW'(MAX_RUNS);
  end

  assign run_idx    = RW'(XW'(run_i));
  assign bi_idx     = RW'(XW'(bi_q));
  assign bi_present = (int'(bi_q) < int'(MAX_RUNS)) && present_q[bi_idx];
  assign lpos       = (CW'(sx_q) << 1) + CW'(1);
  assign rpos       = lpos + CW'(1);
  assign out_free   = !out_valid_q || out_ready_i;
  assign take_r     = has_r_q && (kd0_q > kd1_q);
  assign ckey       = take_r ? kd1_q : kd0_q;
  assign crun       = take_r ? cr1_q : cr0_q;
  assign cpos       = take_r ? RW'(cl_q + RW'(1)) : cl_q;
  assign size_dec   = size_q - HW'(1);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;   present_d = present_q; size_d = size_q;
    loaded_d = loaded_q; eff_d = eff_q;         bi_d = bi_q;
    merging_d = merging_q; bld_d = bld_q;       has_r_d = has_r_q;
    sx_d = sx_q; bj_d = bj_q; srun_d = srun_q;  top_d = top_q;
    cl_d = cl_q; cr0_d = cr0_q; cr1_d = cr1_q;  skey_d = skey_q;
    out_valid_d = out_valid_q && !out_ready_i;
    done_d = done_q; out_key_d = out_key_q;     out_run_d = out_run_q;
    k_we = 1'b0; k_wa = run_idx; k_wd = key_i;
    k_re0 = 1'b0; k_re1 = 1'b0; k_ra0 = sd0_q; k_ra1 = sd1_q;
    s_we = 1'b0; s_wa = sx_q; s_wd = srun_q;
    s_re0 = 1'b0; s_re1 = 1'b0; s_ra0 = sx_q; s_ra1 = RW'(rpos);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!merging_q) begin
            if ((kind_i == KIND_FIRST || kind_i == KIND_EMPTY)
                && (XW'(run_i) < XW'(eff_w))) begin
              if (kind_i == KIND_FIRST) begin
                k_we = 1'b1;
                present_d[run_idx] = 1'b1;
              end else begin
                present_d[run_idx] = 1'b0;
              end
              loaded_d = loaded_q + CountW'(1);
              if (loaded_d >= eff_w) begin
                eff_d   = eff_w;
                bi_d    = '0;
                size_d  = '0;
                state_d = ST_FILL;
              end
            end
          end else if (kind_i == KIND_NEXT) begin
            k_we    = 1'b1;
            k_wa    = top_q;
            skey_d  = key_i;
            srun_d  = top_q;
            sx_d    = '0;
            bld_d   = 1'b0;
            state_d = ST_SRD;
          end else if (kind_i == KIND_EMPTY) begin
            size_d = size_dec;
            bld_d  = 1'b0;
            sx_d   = '0;
            if (size_dec == '0) begin
              state_d = ST_DONE;
            end else begin
              s_re0   = 1'b1;
              s_ra0   = RW'(size_dec);
              state_d = ST_SKEY;
            end
          end
        end
      end
      ST_FILL: begin
        if (bi_present) begin
          s_we   = 1'b1;
          s_wa   = RW'(size_q);
          s_wd   = bi_idx;
          size_d = size_q + HW'(1);
        end
        bi_d = bi_q + CountW'(1);
        if (bi_d == eff_q) begin
          merging_d = 1'b1;
          if (size_d == '0) begin
            state_d = ST_DONE;
          end else if (size_d < HW'(2)) begin
            state_d = ST_ERD;
          end else begin
            bj_d    = RW'((size_d >> 1) - HW'(1));
            sx_d    = bj_d;
            bld_d   = 1'b1;
            state_d = ST_SLOAD;
          end
        end
      end
      ST_SLOAD: begin
        s_re0   = 1'b1;
        state_d = ST_SKEY;
      end
      ST_SKEY: begin
        srun_d  = sd0_q;
        k_re0   = 1'b1;
        state_d = ST_SKLAT;
      end
      ST_SKLAT: begin
        skey_d  = kd0_q;
        state_d = ST_SRD;
      end
      ST_SRD: begin
        if (lpos >= CW'(size_q)) begin
          // leaf reached: settle the sifted run here
          s_we = 1'b1;
          if (bld_q && bj_q != '0) begin
            bj_d    = bj_q - RW'(1);
            sx_d    = bj_d;
            state_d = ST_SLOAD;
          end else begin
            state_d = ST_ERD;
          end
        end else begin
          s_re0   = 1'b1;
          s_ra0   = RW'(lpos);
          has_r_d = rpos < CW'(size_q);
          s_re1   = has_r_d;
          cl_d    = RW'(lpos);
          state_d = ST_SKREAD;
        end
      end
      ST_SKREAD: begin
        cr0_d   = sd0_q;
        cr1_d   = sd1_q;
        k_re0   = 1'b1;
        k_re1   = has_r_q;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        s_we = 1'b1;
        if (skey_q < ckey) begin
          if (bld_q && bj_q != '0) begin
            bj_d    = bj_q - RW'(1);
            sx_d    = bj_d;
            state_d = ST_SLOAD;
          end else begin
            state_d = ST_ERD;
          end
        end else begin
          // promote the smaller child, move down
          s_wd    = crun;
          sx_d    = cpos;
          state_d = ST_SRD;
        end
      end
      ST_ERD: begin
        s_re0   = 1'b1;
        s_ra0   = '0;
        state_d = ST_EKEY;
      end
      ST_EKEY: begin
        top_d   = sd0_q;
        k_re0   = 1'b1;
        state_d = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          done_d      = 1'b0;
          out_key_d   = kd0_q;
          out_run_d   = RunW'(XW'(top_q));
          state_d     = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          done_d      = 1'b1;
          out_key_d   = '0;
          out_run_d   = '0;
          present_d   = '0;
          size_d      = '0;
          loaded_d    = '0;
          merging_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_count_q <= CountW'(16);
      present_q   <= '0;
      size_q      <= '0;
      loaded_q    <= '0;
      eff_q       <= CountW'(1);
      bi_q        <= '0;
      merging_q   <= 1'b0;
      bld_q       <= 1'b0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) run_count_q <= cfg_wdata_i;
      present_q   <= present_d;
      size_q      <= size_d;
      loaded_q    <= loaded_d;
      eff_q       <= eff_d;
      bi_q        <= bi_d;
      merging_q   <= merging_d;
      bld_q       <= bld_d;
      out_valid_q <= out_valid_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    has_r_q   <= has_r_d;
    sx_q      <= sx_d;
    bj_q      <= bj_d;
    srun_q    <= srun_d;
    top_q     <= top_d;
    cl_q      <= cl_d;
    cr0_q     <= cr0_d;
    cr1_q     <= cr1_d;
    skey_q    <= skey_d;
    out_key_q <= out_key_d;
    out_run_q <= out_run_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_run_o   = out_run_q;
  assign done_res_o  = done_q;

`ifndef NO_ASSERTIONS
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(size_q) <= int'(MAX_RUNS))
    else $error("heap size beyond capacity");

  a_merge_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && merging_q) |-> (size_q != '0))
    else $error("merge phase with empty heap");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (out_key_q == '0 && out_run_q == '0))
    else $error("done result carries key or run");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (!merging_q && loaded_q == '0))
    else $error("pass state not cleared after done");
`endif

endmodule
